// File: src/forgiving_base64_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the forgiving base64 decoder
// Shared property shorthands used by the port checker.
// ---------------------------------------------------------------------------
`ifndef FORGIVING_BASE64_DECODER_DEFINES_SVH
`define FORGIVING_BASE64_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FB64D_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fb64d assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FB64D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fb64d assertion failed");

`endif

// File: src/fb64d_pkg.sv
// ---------------------------------------------------------------------------
// Forgiving base64 decoder package
// Status codes, character constants, result type and the sextet map.
// ---------------------------------------------------------------------------
package fb64d_pkg;

	// Final status of one encoded string.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_PADDING   = 2'd2,
		ST_REMAINDER = 2'd3
	} status_t;

	// Characters with a special meaning.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PAD   = 8'h3d;

	// One result beat.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		status_t    status;
	} res_t;

	// Bit 6 set means the character is not in the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'h00;
			if (c >= 8'h41 && c <= 8'h5a) begin
				t = c - 8'h41;
				return {1'b0, t[5:0]};
			end else if (c >= 8'h61 && c <= 8'h7a) begin
				t = c - 8'h47;
				return {1'b0, t[5:0]};
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c + 8'h04;
				return {1'b0, t[5:0]};
			end else if (c == CH_PLUS) begin
				return 7'd62;
			end else if (c == CH_SLASH) begin
				return 7'd63;
			end
			return 7'd64;
		end
	endfunction

endpackage

// File: src/fb64d_ifs.sv
// ---------------------------------------------------------------------------
// Forgiving base64 decoder channels
// Valid/ready interfaces for the character input and the result output.
// ---------------------------------------------------------------------------
interface fb64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface fb64d_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic [1:0] out_status;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output out_status, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_last,
		input out_status, output ready);
endinterface

// File: src/forgiving_base64_decoder.sv
// ---------------------------------------------------------------------------
// Forgiving base64 decoder
// Decodes one character per cycle while chars.ready is high into byte beats.
// ---------------------------------------------------------------------------
// Usage: characters enter on the chars channel, one per beat, with in_last on
// the final character of a string. Whitespace is skipped. Every fourth
// alphabet character yields three result beats; the string end yields the
// leftover bytes, the last beat flagged out_last, or a single status beat
// (out_valid 0, out_last 1) when no byte goes out on that character.
// A character's first result beat appears in the cycle after its beat is
// taken. Characters are taken one per cycle while each makes at most one
// result beat and the receiver is ready; each extra beat holds chars.ready
// low while it waits, since the result buffer drains one beat per cycle on
// the results port while results.ready is high. The buffer may refill in
// the same cycle its final beat leaves.
// Reset clears the decoding state and empties the result buffer. When the
// receiver stalls, the buffered beats wait and chars.ready falls once the
// buffer cannot be emptied in the current cycle.
// ---------------------------------------------------------------------------
module forgiving_base64_decoder
	import fb64d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	fb64d_char_if.sink         chars,
	fb64d_res_if.source        results
);

	// Decoding state.
	logic [17:0] acc_q;
	logic [1:0]  gc_q;
	logic [1:0]  pad_q;
	status_t     st_q;

	// Result buffer.
	res_t        res_q [3];
	logic [1:0]  rem_q;
	logic [1:0]  ptr_q;

	logic [17:0] acc_d;
	logic [1:0]  gc_d;
	logic [1:0]  pad_d;
	status_t     st_d;
	res_t        res_d [3];
	logic [1:0]  n_d;
	logic [1:0]  nd;
	logic [7:0]  dat [3];
	logic [6:0]  sx;
	logic [23:0] grp;
	logic        is_ws;
	logic        grp_done;
	logic        take;
	logic        give;

	// Handshakes.
	assign give  = results.valid && results.ready;
	assign chars.ready = (rem_q == 2'd0) || (rem_q == 2'd1 && results.ready);
	assign take  = chars.valid && chars.ready;

	// Per-character decode and result formation.
	always_comb begin
		acc_d    = acc_q;
		gc_d     = gc_q;
		pad_d    = pad_q;
		st_d     = st_q;
		grp_done = 1'b0;
		sx       = sextet_of(chars.in_char);
		grp      = {acc_q, sx[5:0]};
		is_ws    = chars.in_char == CH_TAB || chars.in_char == CH_LF ||
			chars.in_char == CH_FF || chars.in_char == CH_CR ||
			chars.in_char == CH_SPACE;
		nd       = 2'd0;
		dat[0]   = 8'h00;
		dat[1]   = 8'h00;
		dat[2]   = 8'h00;

		if (st_q == ST_OK && !is_ws) begin
			if (chars.in_char == CH_PAD) begin
				if (gc_q < 2'd2 || ({1'b0, gc_q} + {1'b0, pad_q}) >= 3'd4) begin
					st_d = ST_PADDING;
				end else begin
					pad_d = pad_q + 2'd1;
				end
			end else if (sx[6]) begin
				st_d = ST_ILLEGAL;
			end else if (pad_q != 2'd0) begin
				st_d = ST_PADDING;
			end else if (gc_q == 2'd3) begin
				grp_done = 1'b1;
				acc_d    = '0;
				gc_d     = 2'd0;
			end else begin
				acc_d = {acc_q[11:0], sx[5:0]};
				gc_d  = gc_q + 2'd1;
			end
		end

		// A completed group leaves nothing over, so the tail check is moot then.
		if (grp_done) begin
			dat[0] = grp[23:16];
			dat[1] = grp[15:8];
			dat[2] = grp[7:0];
			nd     = 2'd3;
		end else if (chars.in_last && st_d == ST_OK) begin
			if (pad_d != 2'd0 && ({1'b0, gc_d} + {1'b0, pad_d}) != 3'd4) begin
				st_d = ST_PADDING;
			end else if (gc_d == 2'd1) begin
				st_d = ST_REMAINDER;
			end else if (gc_d == 2'd2) begin
				dat[0] = acc_d[11:4];
				nd     = 2'd1;
			end else if (gc_d == 2'd3) begin
				dat[0] = acc_d[17:10];
				dat[1] = acc_d[9:2];
				nd     = 2'd2;
			end
		end

		for (int k = 0; k < 3; k++) begin
			res_d[k].data   = dat[k];
			res_d[k].valid  = 2'(k) < nd;
			res_d[k].last   = chars.in_last && (2'(k) == nd - 2'd1);
			res_d[k].status = ST_OK;
		end

		// String end with no byte: a lone status beat.
		n_d = nd;
		if (chars.in_last && nd == 2'd0) begin
			res_d[0].data   = 8'h00;
			res_d[0].valid  = 1'b0;
			res_d[0].last   = 1'b1;
			res_d[0].status = st_d;
			n_d             = 2'd1;
		end

		// Every string starts afresh.
		if (chars.in_last) begin
			acc_d = '0;
			gc_d  = 2'd0;
			pad_d = 2'd0;
			st_d  = ST_OK;
		end
	end

	// State and buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			gc_q  <= 2'd0;
			pad_q <= 2'd0;
			st_q  <= ST_OK;
			rem_q <= 2'd0;
			ptr_q <= 2'd0;
		end else begin
			if (give) begin
				rem_q <= rem_q - 2'd1;
				ptr_q <= ptr_q + 2'd1;
			end
			if (take) begin
				acc_q <= acc_d;
				gc_q  <= gc_d;
				pad_q <= pad_d;
				st_q  <= st_d;
				rem_q <= n_d;
				ptr_q <= 2'd0;
			end
		end
	end

	// Buffer payload.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q[0] <= res_d[0];
			res_q[1] <= res_d[1];
			res_q[2] <= res_d[2];
		end
	end

	// Output beat.
	assign results.valid      = rem_q != 2'd0;
	assign results.out_byte   = res_q[ptr_q].data;
	assign results.out_valid  = res_q[ptr_q].valid;
	assign results.out_last   = res_q[ptr_q].last;
	assign results.out_status = res_q[ptr_q].status;

endmodule

// File: src/fb64d_checker.sv
// ---------------------------------------------------------------------------
// Forgiving base64 decoder port checker
// Watches the result port for consistency of the result fields over time.
// ---------------------------------------------------------------------------
`include "forgiving_base64_decoder_defines.svh"

module fb64d_port_checker
	import fb64d_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last,
	input logic [1:0] out_status
);

	// A beat without data is the status beat that closes a string.
	`FB64D_ASSERT_SAME(a_nodata_is_status, clk, arst_n, res_valid && !out_valid, out_last && out_byte == 8'h00)

	// Only the closing beat carries a status.
	`FB64D_ASSERT_SAME(a_status_on_last, clk, arst_n, res_valid && !out_last, out_status == ST_OK)

	// An error status never comes with a data byte.
	`FB64D_ASSERT_SAME(a_error_no_data, clk, arst_n, res_valid && out_status != ST_OK, !out_valid)

	// A stalled beat holds.
	`FB64D_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(out_last) && $stable(out_status))

endmodule

bind forgiving_base64_decoder fb64d_port_checker u_fb64d_port_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.out_byte   (results.out_byte),
	.out_valid  (results.out_valid),
	.out_last   (results.out_last),
	.out_status (results.out_status)
);
